/* src/bfca_pkg.sv */
// ---------------------------------------------------------------------------
// bfca_pkg
// shared constants, types and codes of the best-fit coalescing allocator
// ---------------------------------------------------------------------------
package bfca_pkg;

    localparam int HEAP_BYTES   = 1024;
    localparam int FREE_ENTRIES = 128;
    localparam int HEADER_BYTES = 4;

    // field widths of the ports
    localparam int ADDR_W = 10;
    localparam int REQ_W  = 10;

    // offsets and lengths hold 0 .. HEAP_BYTES
    localparam int OFS_W  = $clog2(HEAP_BYTES + 1);
    localparam int SUM_W  = OFS_W + 1;
    localparam int HEAP_W = $clog2(HEAP_BYTES);
    localparam int IDX_W  = $clog2(FREE_ENTRIES);
    localparam int CNT_W  = $clog2(FREE_ENTRIES + 1);

    localparam logic [CNT_W-1:0]  FULL_COUNT   = CNT_W'(FREE_ENTRIES);
    localparam logic [SUM_W-1:0]  HEAP_LIMIT   = SUM_W'(HEAP_BYTES);
    localparam logic [OFS_W-1:0]  HEADER_OFS   = OFS_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HEADER_ADDR  = ADDR_W'(HEADER_BYTES);

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] len;
    } hole_t;

    localparam hole_t RESET_HOLE = '{start: '0, len: OFS_W'(HEAP_BYTES)};

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FIT    = 2'd2,
        ST_LIST_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_COMMIT,
        S_FREE_COMMIT,
        S_MERGE_LAST,
        S_DONE
    } state_t;

endpackage

/* src/best_fit_coalescing_allocator.sv */
// ---------------------------------------------------------------------------
// best_fit_coalescing_allocator
// best-fit heap allocator over a free list of holes, coalescing on free
// ---------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------
//  request | req_valid | req_stall | operation, request_size, block_address
//  result  | rsp_valid | rsp_stall | user_address, status
//
//  one request at a time: req_stall is held from accept until the result is
//  registered; the work is a scan of the hole memory (one entry read per cycle
//  on its single read port, over all hole_count entries), then a commit and the
//  done state
//  a merge with holes on both sides passes through S_MERGE_LAST to move the last entry
//  an oversize allocate or a free below the header skips the scan and goes to S_DONE
//  reset is asynchronous and needs no clearing pass: a flag stands for hole 0
//  a stalled result sits in the output register while the next beat is taken
//
module best_fit_coalescing_allocator
    import bfca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              operation,
    input  logic [REQ_W-1:0]  request_size,
    input  logic [ADDR_W-1:0] block_address,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [ADDR_W-1:0] user_address,
    output logic [1:0]        status
);

    // hole list memory: start and length of each hole
    hole_t hole_mem [FREE_ENTRIES];
    hole_t hole_q_reg;
    logic  hole_dflt_reg;
    logic  entry0_valid_reg;
    logic  hole_re;
    logic  hole_we;
    logic  [IDX_W-1:0] hole_raddr;
    logic  [IDX_W-1:0] hole_waddr;
    hole_t hole_wdata;
    hole_t hole_rd;

    // block size store, one entry per heap offset, contents undefined until written
    logic [OFS_W-1:0]  store_mem [HEAP_BYTES];
    logic [OFS_W-1:0]  store_q_reg;
    logic              store_re;
    logic              store_we;
    logic [HEAP_W-1:0] store_raddr;
    logic [HEAP_W-1:0] store_waddr;
    logic [OFS_W-1:0]  store_wdata;

    // control and working registers
    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [OFS_W-1:0]  total_reg, total_next;
    logic [HEAP_W-1:0] blk_start_reg, blk_start_next;
    logic [CNT_W-1:0]  hole_count_reg, hole_count_next;
    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]  eval_idx_reg, eval_idx_next;
    logic [IDX_W-1:0]  last_idx_reg, last_idx_next;

    // best-fit tracking
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_idx_reg, pick_idx_next;
    logic [OFS_W-1:0]  best_len_reg, best_len_next;
    logic [OFS_W-1:0]  best_start_reg, best_start_next;

    // neighbor tracking
    logic              has_prev_reg, has_prev_next;
    logic [IDX_W-1:0]  prev_idx_reg, prev_idx_next;
    logic [OFS_W-1:0]  prev_start_reg, prev_start_next;
    logic [OFS_W-1:0]  prev_len_reg, prev_len_next;
    logic              has_next_reg, has_next_next;
    logic [IDX_W-1:0]  next_idx_reg, next_idx_next;
    logic [OFS_W-1:0]  next_len_reg, next_len_next;

    // pending and delivered result
    logic [ADDR_W-1:0] res_user_reg, res_user_next;
    status_t           res_status_reg, res_status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0] rsp_user_reg, rsp_user_next;
    status_t           rsp_status_reg, rsp_status_next;

    // helpers
    logic [SUM_W-1:0]  req_total;
    logic [SUM_W-1:0]  hole_end;
    logic [SUM_W-1:0]  blk_end;
    logic [OFS_W-1:0]  blk_start_ofs;
    logic [OFS_W-1:0]  merged_next;
    logic [OFS_W-1:0]  prev_add;
    hole_t             prev_upd;
    logic              take_prev;
    logic [CNT_W-1:0]  count_m1;
    logic              accept;

    assign accept        = req_valid && !req_stall;
    assign req_stall     = (state_reg != S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign user_address  = rsp_user_reg;
    assign status        = rsp_status_reg;

    // hole 0 reads as the whole heap until it is first written
    assign hole_rd       = hole_dflt_reg ? RESET_HOLE : hole_q_reg;

    assign req_total     = SUM_W'(request_size) + SUM_W'(HEADER_BYTES);
    assign blk_start_ofs = OFS_W'(blk_start_reg);
    assign hole_end      = SUM_W'(hole_rd.start) + SUM_W'(hole_rd.len);
    assign blk_end       = SUM_W'(blk_start_reg) + SUM_W'(store_q_reg);

    // a hole matching on both sides counts as the after neighbor only
    assign take_prev     = has_prev_reg && !(has_next_reg && (prev_idx_reg == next_idx_reg));
    assign merged_next   = next_len_reg + store_q_reg;
    assign prev_add      = has_next_reg ? merged_next : store_q_reg;
    assign prev_upd      = '{start: prev_start_reg, len: prev_len_reg + prev_add};
    assign count_m1      = hole_count_reg - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        total_next      = total_reg;
        blk_start_next  = blk_start_reg;
        hole_count_next = hole_count_reg;
        issue_idx_next  = issue_idx_reg;
        eval_valid_next = 1'b0;
        eval_idx_next   = eval_idx_reg;
        last_idx_next   = last_idx_reg;
        found_next      = found_reg;
        pick_idx_next   = pick_idx_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        has_prev_next   = has_prev_reg;
        prev_idx_next   = prev_idx_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        has_next_next   = has_next_reg;
        next_idx_next   = next_idx_reg;
        next_len_next   = next_len_reg;
        res_user_next   = res_user_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_user_next   = rsp_user_reg;
        rsp_status_next = rsp_status_reg;

        hole_re     = 1'b0;
        hole_raddr  = issue_idx_reg[IDX_W-1:0];
        hole_we     = 1'b0;
        hole_waddr  = pick_idx_reg;
        hole_wdata  = hole_rd;
        store_re    = 1'b0;
        store_raddr = HEAP_W'(block_address - HEADER_ADDR);
        store_we    = 1'b0;
        store_waddr = blk_start_reg;
        store_wdata = merged_next;

        // result register drains independently of the work
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(operation);
                    total_next      = OFS_W'(req_total);
                    blk_start_next  = HEAP_W'(block_address - HEADER_ADDR);
                    issue_idx_next  = '0;
                    found_next      = 1'b0;
                    has_prev_next   = 1'b0;
                    has_next_next   = 1'b0;
                    res_user_next   = '0;
                    res_status_next = ST_OK;
                    if (op_t'(operation) == OP_ALLOC)
                    begin
                        if (req_total > HEAP_LIMIT)
                        begin
                            res_status_next = ST_TOO_LARGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (block_address < HEADER_ADDR)
                    begin
                        // free below the header is ignored
                        state_next = S_DONE;
                    end
                    else
                    begin
                        store_re   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue side: one entry read per cycle
                if (issue_idx_reg < hole_count_reg)
                begin
                    hole_re         = 1'b1;
                    issue_idx_next  = issue_idx_reg + CNT_W'(1);
                    eval_valid_next = 1'b1;
                    eval_idx_next   = issue_idx_reg[IDX_W-1:0];
                end
                else if (!eval_valid_reg)
                begin
                    state_next = (op_reg == OP_ALLOC) ? S_ALLOC_COMMIT : S_FREE_COMMIT;
                end

                // evaluate side: entry read in the previous cycle
                if (eval_valid_reg)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if ((hole_rd.len >= total_reg)
                            && (!found_reg || (hole_rd.len < best_len_reg)))
                        begin
                            found_next      = 1'b1;
                            pick_idx_next   = eval_idx_reg;
                            best_len_next   = hole_rd.len;
                            best_start_next = hole_rd.start;
                        end
                    end
                    else
                    begin
                        if (hole_end == SUM_W'(blk_start_reg))
                        begin
                            has_prev_next   = 1'b1;
                            prev_idx_next   = eval_idx_reg;
                            prev_start_next = hole_rd.start;
                            prev_len_next   = hole_rd.len;
                        end
                        if (blk_end == SUM_W'(hole_rd.start))
                        begin
                            has_next_next = 1'b1;
                            next_idx_next = eval_idx_reg;
                            next_len_next = hole_rd.len;
                        end
                    end
                end
            end

            S_ALLOC_COMMIT:
            begin
                if (!found_reg)
                begin
                    res_status_next = ST_NO_FIT;
                end
                else
                begin
                    // carve from the front of the chosen hole
                    hole_we     = 1'b1;
                    hole_waddr  = pick_idx_reg;
                    hole_wdata  = '{start: best_start_reg + total_reg,
                                    len:   best_len_reg - total_reg};
                    store_we    = (SUM_W'(best_start_reg) < HEAP_LIMIT);
                    store_waddr = best_start_reg[HEAP_W-1:0];
                    store_wdata = total_reg;
                    res_user_next   = ADDR_W'(best_start_reg + HEADER_OFS);
                    res_status_next = ST_OK;
                end
                state_next = S_DONE;
            end

            S_FREE_COMMIT:
            begin
                state_next = S_DONE;
                if (take_prev && has_next_reg)
                begin
                    // grow the before hole now, fetch the last entry to fill the after slot
                    hole_we       = 1'b1;
                    hole_waddr    = prev_idx_reg;
                    hole_wdata    = prev_upd;
                    store_we      = 1'b1;
                    store_wdata   = merged_next;
                    hole_re       = 1'b1;
                    hole_raddr    = count_m1[IDX_W-1:0];
                    last_idx_next = count_m1[IDX_W-1:0];
                    state_next    = S_MERGE_LAST;
                end
                else if (has_next_reg)
                begin
                    hole_we     = 1'b1;
                    hole_waddr  = next_idx_reg;
                    hole_wdata  = '{start: blk_start_ofs, len: merged_next};
                    store_we    = 1'b1;
                    store_wdata = merged_next;
                end
                else if (take_prev)
                begin
                    hole_we    = 1'b1;
                    hole_waddr = prev_idx_reg;
                    hole_wdata = prev_upd;
                end
                else if (hole_count_reg >= FULL_COUNT)
                begin
                    // no room: the block is dropped
                    res_status_next = ST_LIST_FULL;
                end
                else
                begin
                    hole_we         = 1'b1;
                    hole_waddr      = hole_count_reg[IDX_W-1:0];
                    hole_wdata      = '{start: blk_start_ofs, len: store_q_reg};
                    hole_count_next = hole_count_reg + CNT_W'(1);
                end
            end

            S_MERGE_LAST:
            begin
                // the last entry read before the prev update: forward it if it is prev
                hole_we         = 1'b1;
                hole_waddr      = next_idx_reg;
                hole_wdata      = (last_idx_reg == prev_idx_reg) ? prev_upd : hole_rd;
                hole_count_next = count_m1;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_user_next   = res_user_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hole memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (hole_we)
        begin
            hole_mem[hole_waddr] <= hole_wdata;
        end
        if (hole_re)
        begin
            hole_q_reg <= hole_mem[hole_raddr];
        end
    end

    // block size store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (store_re)
        begin
            store_q_reg <= store_mem[store_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            hole_count_reg   <= CNT_W'(1);
            entry0_valid_reg <= 1'b0;
            hole_dflt_reg    <= 1'b0;
            eval_valid_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hole_count_reg <= hole_count_next;
            eval_valid_reg <= eval_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (hole_we && (hole_waddr == '0))
            begin
                entry0_valid_reg <= 1'b1;
            end
            if (hole_re)
            begin
                hole_dflt_reg <= (hole_raddr == '0) && !entry0_valid_reg;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        total_reg      <= total_next;
        blk_start_reg  <= blk_start_next;
        issue_idx_reg  <= issue_idx_next;
        eval_idx_reg   <= eval_idx_next;
        last_idx_reg   <= last_idx_next;
        found_reg      <= found_next;
        pick_idx_reg   <= pick_idx_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        has_prev_reg   <= has_prev_next;
        prev_idx_reg   <= prev_idx_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        has_next_reg   <= has_next_next;
        next_idx_reg   <= next_idx_next;
        next_len_reg   <= next_len_next;
        res_user_reg   <= res_user_next;
        res_status_reg <= res_status_next;
        rsp_user_reg   <= rsp_user_next;
        rsp_status_reg <= rsp_status_next;
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hole_count_reg != '0) && (hole_count_reg <= FULL_COUNT))
        else $error("hole count out of range");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hole_count_reg) |->
            ($past(state_reg) == S_FREE_COMMIT) || ($past(state_reg) == S_MERGE_LAST))
        else $error("hole count changed outside a free commit");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start work");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the done state");

endmodule
